### src/tlqs_pkg.sv
`default_nettype none

package tlqs_pkg;

   // Size of the process table; the ring of cells has one cell per entry.
   localparam int MAX_PROCS = 64;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int LOCK_W    = IDX_W + 1;
   localparam int TIME_W    = 16;
   localparam int ID_W      = 7;

   localparam logic [IDX_W-1:0]  LAST_STEP      = IDX_W'(MAX_PROCS - 1);
   localparam logic [LOCK_W-1:0] LOCK_NONE      = {LOCK_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 16'd1000;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE
   } state_type;

   // One process table entry.
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] remaining;
      logic              is_user;
   } entry_type;

   // Control from the sequencer to the head unit of the ring.
   typedef struct packed {
      logic              clear;
      logic              scan;
      logic              dec;
      logic [IDX_W-1:0]  step;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] now;
      logic [LOCK_W-1:0] lock;
      logic [IDX_W-1:0]  sel;
   } head_ctl_type;

   // Scan results and update status from the head unit.
   typedef struct packed {
      logic             done;
      logic             sys_found;
      logic [IDX_W-1:0] sys_idx;
      logic             user_found;
      logic [IDX_W-1:0] user_idx;
      logic             lock_live;
      logic             dec_hit;
      logic             dec_zero;
   } head_stat_type;

   // Result word fields, last field in the lowest bits.
   typedef struct packed {
      logic              halted;
      logic              all_done;
      logic [TIME_W-1:0] tick_time;
      logic              idle;
      logic              running_is_user;
      logic [ID_W-1:0]   running_id;
   } rsp_type;

endpackage

`default_nettype wire

### src/tlqs_cell.sv
`default_nettype none

module tlqs_cell
   import tlqs_pkg::*;
(
   input  wire       clock,
   input  wire       load_en,
   input  entry_type load_word,
   input  wire       shift_en,
   input  entry_type shift_in,
   output entry_type q
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_word;
      end else if (shift_en) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

### src/tlqs_head.sv
`default_nettype none

module tlqs_head
   import tlqs_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  head_ctl_type  ctl,
   input  entry_type     head_word,
   output entry_type     tail_word,
   output head_stat_type stat
);

   logic             occupied;
   logic             live;
   logic             ready;
   logic             take_sys;
   logic             take_user;
   logic             at_lock;

   logic              done_ff,       done_in;
   logic              sys_found_ff,  sys_found_in;
   logic [IDX_W-1:0]  sys_idx_ff,    sys_idx_in;
   logic [TIME_W-1:0] sys_arr_ff,    sys_arr_in;
   logic              user_found_ff, user_found_in;
   logic [IDX_W-1:0]  user_idx_ff,   user_idx_in;
   logic [TIME_W-1:0] user_arr_ff,   user_arr_in;
   logic              lock_live_ff,  lock_live_in;

   // The entry at the head of the ring has the index of the current step.
   assign occupied  = CNT_W'(ctl.step) < ctl.count;
   assign live      = occupied && (head_word.remaining != '0);
   assign ready     = live && (head_word.arrival <= ctl.now);
   // Strict compare keeps the lower index on equal arrival times.
   assign take_sys  = ready && !head_word.is_user &&
                      (!sys_found_ff || (head_word.arrival < sys_arr_ff));
   assign take_user = ready && head_word.is_user &&
                      (!user_found_ff || (head_word.arrival < user_arr_ff));
   assign at_lock   = {1'b0, ctl.step} == ctl.lock;

   always_comb begin
      done_in       = done_ff;
      sys_found_in  = sys_found_ff;
      sys_idx_in    = sys_idx_ff;
      sys_arr_in    = sys_arr_ff;
      user_found_in = user_found_ff;
      user_idx_in   = user_idx_ff;
      user_arr_in   = user_arr_ff;
      lock_live_in  = lock_live_ff;
      if (ctl.clear) begin
         done_in       = 1'b1;
         sys_found_in  = 1'b0;
         user_found_in = 1'b0;
         lock_live_in  = 1'b0;
      end else if (ctl.scan) begin
         if (live) begin
            done_in = 1'b0;
         end
         if (take_sys) begin
            sys_found_in = 1'b1;
            sys_idx_in   = ctl.step;
            sys_arr_in   = head_word.arrival;
         end
         if (take_user) begin
            user_found_in = 1'b1;
            user_idx_in   = ctl.step;
            user_arr_in   = head_word.arrival;
         end
         if (at_lock && live) begin
            lock_live_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff       <= 1'b1;
         sys_found_ff  <= 1'b0;
         user_found_ff <= 1'b0;
         lock_live_ff  <= 1'b0;
      end else begin
         done_ff       <= done_in;
         sys_found_ff  <= sys_found_in;
         user_found_ff <= user_found_in;
         lock_live_ff  <= lock_live_in;
      end
      sys_idx_ff  <= sys_idx_in;
      sys_arr_ff  <= sys_arr_in;
      user_idx_ff <= user_idx_in;
      user_arr_ff <= user_arr_in;
   end

   // On the update pass the chosen entry loses one time unit as it wraps round.
   always_comb begin
      tail_word = head_word;
      if (stat.dec_hit) begin
         tail_word.remaining = head_word.remaining - TIME_W'(1);
      end
   end

   always_comb begin
      stat.done       = done_ff;
      stat.sys_found  = sys_found_ff;
      stat.sys_idx    = sys_idx_ff;
      stat.user_found = user_found_ff;
      stat.user_idx   = user_idx_ff;
      stat.lock_live  = lock_live_ff;
      stat.dec_hit    = ctl.dec && (ctl.step == ctl.sel);
      stat.dec_zero   = head_word.remaining == TIME_W'(1);
   end

endmodule

`default_nettype wire

### src/two_level_queue_scheduler.sv
`default_nettype none

// Channel    Direction  Handshake            Contents
// req        in         req_tvalid/tready    tuser: kind; tdata: process entry fields
// rsp        out        rsp_tvalid/tready    tdata: scheduling decision of one tick
// csr        in         csr_wr_en            csr_wr_data: idle limit
//
// A tick that runs a process makes a pass that rotates the ring past the head unit to
// find the candidates, then a decision, and a second pass that decrements the chosen
// entry. An idle, halted or all-done tick skips the second pass.
// Reset clears the count, time, lock and halt flag; table contents stay undefined.
// A stalled response holds the decision cycle; loads are taken while a response waits.

module two_level_queue_scheduler
   import tlqs_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire                    req_tuser,   // [0] kind
   // [15:0] arrival_time, [31:16] burst_time, [32] is_user, rest zero
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [6:0] running_id, [7] running_is_user, [8] idle, [24:9] tick_time,
   // [25] all_done, [26] halted, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                    csr_wr_en,
   input  wire [TIME_W-1:0]       csr_wr_data
);

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [LOCK_W-1:0] lock_ff, lock_in;
   logic              halt_ff, halt_in;
   logic [TIME_W-1:0] limit_ff, limit_in;
   logic [IDX_W-1:0]  sel_ff, sel_in;
   logic              sel_user_ff, sel_user_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Sequencer outputs.
   logic scan_on;
   logic update_on;
   logic decide_on;
   logic tick_fire;
   logic load_fire;

   logic              out_free;
   logic              last_step;
   logic              quiet;
   logic              found;
   logic [IDX_W-1:0]  pick;
   logic              pick_user;
   logic [TIME_W-1:0] time_next;
   logic              halt_now;

   entry_type     load_word;
   entry_type     cell_q [MAX_PROCS];
   entry_type     tail_word;
   head_ctl_type  ctl;
   head_stat_type stat;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_step = step_ff == LAST_STEP;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_tuser == KIND_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_step) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = (!quiet && found) ? ST_UPDATE : ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      scan_on    = 1'b0;
      update_on  = 1'b0;
      decide_on  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            scan_on = 1'b1;
         end
         ST_DECIDE: begin
            decide_on = out_free;
         end
         ST_UPDATE: begin
            update_on = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign tick_fire = req_tvalid && req_tready && (req_tuser == KIND_TICK);
   assign load_fire = req_tvalid && req_tready && (req_tuser == KIND_LOAD) &&
                      (count_ff < CNT_W'(MAX_PROCS));

   // ------------------------------------------------------------ ring of cells
   // Cell 0 is the head; every cell but the last takes its upper neighbor's entry
   // on each pass step, and the last cell takes the entry coming back from the head.
   assign load_word.arrival   = req_tdata[15:0];
   assign load_word.remaining = req_tdata[31:16];
   assign load_word.is_user   = req_tdata[32];

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      entry_type next_word;
      if (i == MAX_PROCS - 1) begin : g_tail
         assign next_word = tail_word;
      end else begin : g_mid
         assign next_word = cell_q[i+1];
      end
      tlqs_cell u_cell (
         .clock     (clock),
         .load_en   (load_fire && (count_ff == CNT_W'(i))),
         .load_word (load_word),
         .shift_en  (scan_on || update_on),
         .shift_in  (next_word),
         .q         (cell_q[i])
      );
   end

   always_comb begin
      ctl.clear = tick_fire;
      ctl.scan  = scan_on;
      ctl.dec   = update_on;
      ctl.step  = step_ff;
      ctl.count = count_ff;
      ctl.now   = time_ff;
      ctl.lock  = lock_ff;
      ctl.sel   = sel_ff;
   end

   tlqs_head u_head (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_word (cell_q[0]),
      .tail_word (tail_word),
      .stat      (stat)
   );

   // ----------------------------------------------------------------- decision
   // A locked system process keeps the processor; then the earliest ready
   // system process, then the earliest ready user process.
   assign quiet = halt_ff || stat.done;
   assign found = stat.lock_live || stat.sys_found || stat.user_found;

   always_comb begin
      if (stat.lock_live) begin
         pick      = lock_ff[IDX_W-1:0];
         pick_user = 1'b0;
      end else if (stat.sys_found) begin
         pick      = stat.sys_idx;
         pick_user = 1'b0;
      end else begin
         pick      = stat.user_idx;
         pick_user = 1'b1;
      end
   end

   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + TIME_W'(1);
   assign halt_now  = !quiet && !found && (time_next == limit_ff);

   // ------------------------------------------------------------ state update
   always_comb begin
      step_in      = step_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      lock_in      = lock_ff;
      halt_in      = halt_ff;
      limit_in     = limit_ff;
      sel_in       = sel_ff;
      sel_user_in  = sel_user_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (load_fire) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (scan_on || update_on) begin
         step_in = last_step ? '0 : step_ff + IDX_W'(1);
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (decide_on) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.tick_time       = time_ff;
         rsp_data_in.all_done        = stat.done;
         rsp_data_in.halted          = halt_ff || halt_now;
         rsp_data_in.idle            = !quiet && !found;
         rsp_data_in.running_is_user = !quiet && found && pick_user;
         rsp_data_in.running_id      = (!quiet && found) ?
                                       ID_W'({1'b0, pick}) + ID_W'(1) : '0;
         if (!quiet) begin
            time_in = time_next;
            if (!stat.lock_live) begin
               lock_in = LOCK_NONE;
            end
            if (halt_now) begin
               halt_in = 1'b1;
            end
            sel_in      = pick;
            sel_user_in = pick_user;
         end
      end

      // A system process stays locked while it still has time left.
      if (stat.dec_hit && !sel_user_ff) begin
         lock_in = stat.dec_zero ? LOCK_NONE : {1'b0, sel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         lock_ff      <= LOCK_NONE;
         halt_ff      <= 1'b0;
         limit_ff     <= IDLE_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         lock_ff      <= lock_in;
         halt_ff      <= halt_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      sel_user_ff <= sel_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

endmodule

`default_nettype wire

### src/tlqs_checker.sv
`default_nettype none

module tlqs_checker
   import tlqs_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   req_tuser,
   input wire [RSP_DATA_W-1:0]  rsp_tdata,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready
);

   localparam int SCAN_LAT = MAX_PROCS + 2;

   // A waiting response holds its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // A tick keeps the request side closed while the ring rotates.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_TICK) |=> !req_tready)
      else $error("request taken during a tick");

   // After a load the request side stays open.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_LOAD) |=> req_tready)
      else $error("load did not complete in one cycle");

   // A fresh response appears only after a full scan pass.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tuser == KIND_TICK), SCAN_LAT))
      else $error("response without a matching tick");

endmodule

bind two_level_queue_scheduler tlqs_checker u_tlqs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
